@@ rtl/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned STATUS_W = 2;

   localparam logic [FIELD_W-1:0] TOTAL_SPACE_RESET = 16'hFFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_REDUCE = 2'd2,
      KIND_EXPAND = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_MISS     = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

endpackage

@@ rtl/ffsa_if.sv @@
// ----------------------------------------------------------------------------
// ffsa interfaces
// Valid/ready channels for requests, responses and the configuration word.
// ----------------------------------------------------------------------------
interface ffsa_req_if import ffsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic [FIELD_W-1:0]   addr;
   logic [FIELD_W-1:0]   size;

   modport source (output valid, output kind, output addr, output size, input ready);
   modport sink   (input valid, input kind, input addr, input size, output ready);
endinterface

interface ffsa_rsp_if import ffsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [FIELD_W-1:0]   addr_res;
   logic [FIELD_W-1:0]   size_res;

   modport source (output valid, output status, output addr_res, output size_res,
                   input ready);
   modport sink   (input valid, input status, input addr_res, input size_res,
                   output ready);
endinterface

interface ffsa_csr_if import ffsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FIELD_W-1:0]   total_space;

   modport source (output valid, output total_space, input ready);
   modport sink   (input valid, input total_space, output ready);
endinterface

@@ rtl/ffsa_ram.sv @@
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffsa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/first_fit_segment_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit segment allocator with coalescing, table held in one RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (kind, addr, size) and each gives exactly one word
// on rsp_ch (status, addr_res, size_res). The csr_ch word sets the managed
// space and rebuilds the table as one free segment; it is taken only while
// the block is idle.
// The segment table lives in one RAM with a registered read and one write
// port. Allocate and free walk the table one entry per cycle from entry
// zero, then move the tail of the table up or down one entry per cycle to
// open or close a slot.
// One request is worked on at a time; the next request is taken the cycle
// after the result moves to the output register.
// The output register holds a result while the receiver stalls; the block
// still takes the next request and finishes its work, then waits to deliver.
// After reset the block writes the first table entry before it goes idle.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core import ffsa_pkg::*; #(
   parameter int unsigned MAX_SEGMENTS = 64,
   parameter int unsigned ADDR_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   ffsa_req_if.sink   req_ch,
   ffsa_rsp_if.source rsp_ch,
   ffsa_csr_if.sink   csr_ch
);

   localparam int unsigned AW = ADDR_BITS;
   localparam int unsigned IW = $clog2(MAX_SEGMENTS);
   localparam int unsigned XW = $clog2(MAX_SEGMENTS + 2);
   localparam int unsigned CW = (AW > FIELD_W) ? AW : FIELD_W;
   localparam int unsigned SW = CW + 1;
   localparam int unsigned EW = 2 * AW + 1;
   localparam logic [AW-1:0] ADDR_MAX = {AW{1'b1}};
   localparam logic [XW-1:0] MAX_COUNT = XW'(MAX_SEGMENTS);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_SCAN, ST_ALLOC, ST_FREE_NEXT, ST_SHIFT_DN,
      ST_SHIFT_UP, ST_TAKE, ST_LAST, ST_EXPAND, ST_RESP
   } state_type;

   state_type          state_ff;
   kind_type           kind_ff;
   logic [FIELD_W-1:0] addr_ff;
   logic [FIELD_W-1:0] size_ff;
   logic [FIELD_W-1:0] total_ff;
   logic [XW-1:0]      count_ff;
   logic [XW-1:0]      rd_idx_ff;
   logic [XW-1:0]      hit_idx_ff;
   logic [EW-1:0]      cur_ff;
   logic [EW-1:0]      prev_ff;
   logic [AW-1:0]      end_ff;
   logic [XW-1:0]      sh_rd_ff;
   logic [XW-1:0]      sh_wr_ff;
   logic               sh_pend_ff;
   logic [XW-1:0]      shift_d_ff;
   status_type         res_status_ff;
   logic [FIELD_W-1:0] res_addr_ff;
   logic [FIELD_W-1:0] res_size_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [FIELD_W-1:0] rsp_addr_ff;
   logic [FIELD_W-1:0] rsp_size_ff;

   logic          ram_rd_en;
   logic [XW-1:0] ram_rd_idx;
   logic          ram_wr_en;
   logic [XW-1:0] ram_wr_idx;
   logic [EW-1:0] ram_wr_data;
   logic [EW-1:0] rd_data;

   logic          rd_used, cur_used, prev_used;
   logic [AW-1:0] rd_base, rd_len, cur_base, cur_len, prev_base, prev_len;
   logic [AW-1:0] size_aw;
   logic [AW-1:0] init_len;
   logic          req_fire, csr_fire;
   logic          hit_alloc, hit_free, hit;
   logic          split, table_full;
   logic          next_ok, merge_left, merge_right;
   logic [AW-1:0] merged_len;
   logic [XW-1:0] free_d, free_p, hit_next, count_last;
   logic [SW-1:0] exp_sum;
   logic          exp_ovf;
   logic          reduce_ok;

   assign rd_used   = rd_data[EW-1];
   assign rd_base   = rd_data[2*AW-1:AW];
   assign rd_len    = rd_data[AW-1:0];
   assign cur_used  = cur_ff[EW-1];
   assign cur_base  = cur_ff[2*AW-1:AW];
   assign cur_len   = cur_ff[AW-1:0];
   assign prev_used = prev_ff[EW-1];
   assign prev_base = prev_ff[2*AW-1:AW];
   assign prev_len  = prev_ff[AW-1:0];

   assign size_aw  = AW'(CW'(size_ff));
   assign init_len = (CW'(total_ff) > CW'(ADDR_MAX)) ? ADDR_MAX : AW'(CW'(total_ff));

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;

   assign hit_alloc = !rd_used && (CW'(rd_len) >= CW'(size_ff));
   assign hit_free  = rd_used && (CW'(rd_base) == CW'(addr_ff))
                      && (CW'(rd_len) == CW'(size_ff));
   assign hit       = (kind_ff == KIND_ALLOC) ? hit_alloc : hit_free;

   assign split      = CW'(cur_len) > CW'(size_ff);
   assign table_full = count_ff == MAX_COUNT;
   assign count_last = count_ff - XW'(1);

   assign hit_next    = hit_idx_ff + XW'(1);
   assign next_ok     = hit_next < count_ff;
   assign merge_left  = (hit_idx_ff != '0) && !prev_used;
   assign merge_right = next_ok && !rd_used;
   assign merged_len  = (merge_left ? prev_len : '0) + cur_len
                        + (merge_right ? rd_len : '0);
   assign free_d      = XW'(merge_left) + XW'(merge_right);
   assign free_p      = merge_left ? hit_idx_ff : hit_next;

   assign exp_sum   = SW'(end_ff) + SW'(size_ff);
   assign exp_ovf   = exp_sum > SW'(ADDR_MAX);
   assign reduce_ok = !rd_used && (rd_len != '0);

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_idx  = '0;
      ram_wr_en   = 1'b0;
      ram_wr_idx  = '0;
      ram_wr_data = '0;
      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {1'b0, {AW{1'b0}}, init_len};
         end
         ST_IDLE: begin
            if (req_fire) begin
               ram_rd_en  = 1'b1;
               ram_rd_idx = (req_ch.kind == KIND_ALLOC || req_ch.kind == KIND_FREE)
                            ? '0 : count_last;
            end
         end
         ST_SCAN: begin
            ram_rd_en  = rd_idx_ff < count_ff;
            ram_rd_idx = rd_idx_ff;
         end
         ST_ALLOC: begin
            if (!split) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = hit_idx_ff;
               ram_wr_data = {1'b1, cur_base, cur_len};
            end
         end
         ST_FREE_NEXT: begin
            ram_wr_en   = 1'b1;
            ram_wr_idx  = merge_left ? hit_idx_ff - XW'(1) : hit_idx_ff;
            ram_wr_data = {1'b0, (merge_left ? prev_base : cur_base), merged_len};
         end
         ST_SHIFT_DN: begin
            ram_wr_en   = sh_pend_ff;
            ram_wr_idx  = sh_wr_ff;
            ram_wr_data = rd_data;
            ram_rd_en   = sh_rd_ff < count_ff;
            ram_rd_idx  = sh_rd_ff;
         end
         ST_SHIFT_UP: begin
            ram_rd_en  = sh_rd_ff > hit_idx_ff;
            ram_rd_idx = sh_rd_ff;
            if (sh_pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = sh_wr_ff;
               ram_wr_data = rd_data;
            end else if (!(sh_rd_ff > hit_idx_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = hit_next;
               ram_wr_data = {1'b0, cur_base + size_aw, cur_len - size_aw};
            end
         end
         ST_TAKE: begin
            ram_wr_en   = 1'b1;
            ram_wr_idx  = hit_idx_ff;
            ram_wr_data = {1'b1, cur_base, size_aw};
         end
         ST_LAST: begin
            if (kind_ff == KIND_REDUCE && reduce_ok) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = count_last;
               ram_wr_data = {1'b0, rd_base, rd_len - AW'(1)};
            end
         end
         ST_EXPAND: begin
            if (!cur_used && !exp_ovf) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = count_last;
               ram_wr_data = {1'b0, cur_base, cur_len + size_aw};
            end else if (cur_used && !table_full && !exp_ovf) begin
               ram_wr_en   = 1'b1;
               ram_wr_idx  = count_ff;
               ram_wr_data = {1'b0, end_ff, size_aw};
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   ffsa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_idx[IW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_idx[IW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         total_ff     <= TOTAL_SPACE_RESET;
         count_ff     <= XW'(1);
         sh_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               count_ff <= XW'(1);
               state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (csr_fire) begin
                  total_ff <= csr_ch.total_space;
                  state_ff <= ST_INIT;
               end else if (req_fire) begin
                  kind_ff     <= req_ch.kind;
                  addr_ff     <= req_ch.addr;
                  size_ff     <= req_ch.size;
                  res_addr_ff <= '0;
                  res_size_ff <= '0;
                  rd_idx_ff   <= XW'(1);
                  if (req_ch.kind == KIND_ALLOC || req_ch.kind == KIND_FREE) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_LAST;
                  end
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  cur_ff     <= rd_data;
                  hit_idx_ff <= rd_idx_ff - XW'(1);
                  state_ff   <= (kind_ff == KIND_ALLOC) ? ST_ALLOC : ST_FREE_NEXT;
               end else if (rd_idx_ff >= count_ff) begin
                  res_status_ff <= STATUS_MISS;
                  state_ff      <= ST_RESP;
               end else begin
                  prev_ff   <= rd_data;
                  rd_idx_ff <= rd_idx_ff + XW'(1);
               end
            end
            ST_ALLOC: begin
               if (!split) begin
                  res_status_ff <= STATUS_DONE;
                  res_addr_ff   <= FIELD_W'(CW'(cur_base));
                  res_size_ff   <= size_ff;
                  state_ff      <= ST_RESP;
               end else if (table_full) begin
                  res_status_ff <= STATUS_FULL;
                  state_ff      <= ST_RESP;
               end else begin
                  sh_rd_ff   <= count_last;
                  sh_wr_ff   <= count_ff;
                  sh_pend_ff <= 1'b0;
                  state_ff   <= ST_SHIFT_UP;
               end
            end
            ST_SHIFT_UP: begin
               if (sh_pend_ff) begin
                  sh_wr_ff <= sh_wr_ff - XW'(1);
               end
               if (sh_rd_ff > hit_idx_ff) begin
                  sh_rd_ff   <= sh_rd_ff - XW'(1);
                  sh_pend_ff <= 1'b1;
               end else begin
                  sh_pend_ff <= 1'b0;
                  if (!sh_pend_ff) begin
                     count_ff <= count_ff + XW'(1);
                     state_ff <= ST_TAKE;
                  end
               end
            end
            ST_TAKE: begin
               res_status_ff <= STATUS_DONE;
               res_addr_ff   <= FIELD_W'(CW'(cur_base));
               res_size_ff   <= size_ff;
               state_ff      <= ST_RESP;
            end
            ST_FREE_NEXT: begin
               res_status_ff <= STATUS_DONE;
               if (free_d == '0) begin
                  state_ff <= ST_RESP;
               end else begin
                  sh_rd_ff   <= free_p + free_d;
                  sh_wr_ff   <= free_p;
                  sh_pend_ff <= 1'b0;
                  shift_d_ff <= free_d;
                  state_ff   <= ST_SHIFT_DN;
               end
            end
            ST_SHIFT_DN: begin
               if (sh_pend_ff) begin
                  sh_wr_ff <= sh_wr_ff + XW'(1);
               end
               if (sh_rd_ff < count_ff) begin
                  sh_rd_ff   <= sh_rd_ff + XW'(1);
                  sh_pend_ff <= 1'b1;
               end else begin
                  sh_pend_ff <= 1'b0;
                  if (!sh_pend_ff) begin
                     count_ff <= count_ff - shift_d_ff;
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_LAST: begin
               cur_ff <= rd_data;
               end_ff <= rd_base + rd_len;
               if (kind_ff == KIND_REDUCE) begin
                  res_status_ff <= reduce_ok ? STATUS_DONE : STATUS_MISS;
                  state_ff      <= ST_RESP;
               end else begin
                  state_ff <= ST_EXPAND;
               end
            end
            ST_EXPAND: begin
               state_ff <= ST_RESP;
               if (!cur_used) begin
                  res_status_ff <= exp_ovf ? STATUS_OVERFLOW : STATUS_DONE;
               end else if (table_full) begin
                  res_status_ff <= STATUS_FULL;
               end else if (exp_ovf) begin
                  res_status_ff <= STATUS_OVERFLOW;
               end else begin
                  res_status_ff <= STATUS_DONE;
                  count_ff      <= count_ff + XW'(1);
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_size_ff   <= res_size_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_INIT;
            end
         endcase
      end
   end

   assign req_ch.ready    = (state_ff == ST_IDLE) && !csr_ch.valid;
   assign csr_ch.ready    = state_ff == ST_IDLE;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.addr_res = rsp_addr_ff;
   assign rsp_ch.size_res = rsp_size_ff;

   // The table always holds between one and MAX_SEGMENTS segments.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= MAX_COUNT))
      else $error("segment count out of range");

   // Every table write lands inside the RAM.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (ram_wr_idx < MAX_COUNT))
      else $error("table write index out of range");

   // An accepted request always starts work before the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");

   // Only allocate and expand can report a full table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_status_ff == STATUS_FULL)
      |-> (kind_ff == KIND_ALLOC || kind_ff == KIND_EXPAND))
      else $error("table full reported for a request that cannot grow the table");

endmodule

@@ tb/first_fit_segment_allocator_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core_test
// Self-checking bench for the first-fit segment allocator core.
// ----------------------------------------------------------------------------
// A directed sequence walks through the corner cases of allocate, free,
// reduce and expand. It is followed by random phases under several
// managed-space settings. Most frees name a segment that is really in use.
// A shadow copy of the segment table predicts each response word, and
// every response is compared field by field. Both channels stall at random
// except during one steady stretch.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core_test import ffsa_pkg::*; ();

   localparam int unsigned SEG_SLOTS  = 64;
   localparam int unsigned SPACE_MAX  = 65535;
   localparam int unsigned STALL_CAP  = 5000;
   localparam int unsigned SETTLE_CYC = 300;

   typedef struct {
      status_type         status;
      logic [FIELD_W-1:0] addr_res;
      logic [FIELD_W-1:0] size_res;
   } alloc_word_type;

   class segment_table_type;
      int unsigned seg_base[SEG_SLOTS];
      int unsigned seg_len[SEG_SLOTS];
      bit          seg_used[SEG_SLOTS];
      int unsigned seg_count;
      alloc_word_type pending[$];
      int unsigned errors;

      function void rebuild(logic [FIELD_W-1:0] space);
         for (int i = 0; i < SEG_SLOTS; i++) begin
            seg_base[i] = 0;
            seg_len[i]  = 0;
            seg_used[i] = 1'b0;
         end
         seg_len[0] = space;
         seg_count  = 1;
      endfunction

      function void drop_entry(int unsigned i);
         for (int unsigned j = i; j + 1 < seg_count; j++) begin
            seg_base[j] = seg_base[j + 1];
            seg_len[j]  = seg_len[j + 1];
            seg_used[j] = seg_used[j + 1];
         end
         seg_count--;
         seg_base[seg_count] = 0;
         seg_len[seg_count]  = 0;
         seg_used[seg_count] = 1'b0;
      endfunction

      function void open_slot(int unsigned i);
         for (int unsigned j = seg_count; j > i + 1; j--) begin
            seg_base[j] = seg_base[j - 1];
            seg_len[j]  = seg_len[j - 1];
            seg_used[j] = seg_used[j - 1];
         end
         seg_count++;
      endfunction

      function void take_request(kind_type kind, logic [FIELD_W-1:0] addr,
                                 logic [FIELD_W-1:0] size);
         alloc_word_type w;
         int unsigned i;
         int unsigned last;
         int unsigned tail_end;
         w.status   = STATUS_DONE;
         w.addr_res = '0;
         w.size_res = '0;
         last       = seg_count - 1;
         tail_end   = seg_base[last] + seg_len[last];
         case (kind)
            KIND_ALLOC: begin
               i = 0;
               while (i < seg_count && (seg_used[i] || seg_len[i] < size)) i++;
               if (i >= seg_count) begin
                  w.status = STATUS_MISS;
               end else if (seg_len[i] > size && seg_count >= SEG_SLOTS) begin
                  w.status = STATUS_FULL;
               end else begin
                  if (seg_len[i] > size) begin
                     open_slot(i);
                     seg_base[i + 1] = seg_base[i] + size;
                     seg_len[i + 1]  = seg_len[i] - size;
                     seg_used[i + 1] = 1'b0;
                     seg_len[i]      = size;
                  end
                  seg_used[i] = 1'b1;
                  w.addr_res  = FIELD_W'(seg_base[i]);
                  w.size_res  = FIELD_W'(seg_len[i]);
               end
            end
            KIND_FREE: begin
               i = 0;
               while (i < seg_count && !(seg_used[i] && seg_base[i] == addr &&
                                         seg_len[i] == size)) i++;
               if (i >= seg_count) begin
                  w.status = STATUS_MISS;
               end else begin
                  seg_used[i] = 1'b0;
                  if (i > 0 && !seg_used[i - 1]) begin
                     seg_len[i - 1] += seg_len[i];
                     drop_entry(i);
                     i--;
                  end
                  if (i + 1 < seg_count && !seg_used[i + 1]) begin
                     seg_len[i] += seg_len[i + 1];
                     drop_entry(i + 1);
                  end
               end
            end
            KIND_REDUCE: begin
               if (!seg_used[last] && seg_len[last] > 0) seg_len[last]--;
               else w.status = STATUS_MISS;
            end
            default: begin
               if (!seg_used[last]) begin
                  if (tail_end + size > SPACE_MAX) w.status = STATUS_OVERFLOW;
                  else seg_len[last] += size;
               end else if (seg_count >= SEG_SLOTS) begin
                  w.status = STATUS_FULL;
               end else if (tail_end + size > SPACE_MAX) begin
                  w.status = STATUS_OVERFLOW;
               end else begin
                  seg_base[seg_count] = tail_end;
                  seg_len[seg_count]  = size;
                  seg_used[seg_count] = 1'b0;
                  seg_count++;
               end
            end
         endcase
         pending.push_back(w);
      endfunction

      function void check_result(status_type status, logic [FIELD_W-1:0] addr_res,
                                 logic [FIELD_W-1:0] size_res);
         alloc_word_type w;
         if (pending.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         w = pending.pop_front();
         if (status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, status);
            errors++;
         end
         if (addr_res !== w.addr_res) begin
            $error("addr_res: expected %0d, actual %0d", w.addr_res, addr_res);
            errors++;
         end
         if (size_res !== w.size_res) begin
            $error("size_res: expected %0d, actual %0d", w.size_res, size_res);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   bit          no_idle;
   int unsigned stall_cycles = 0;
   segment_table_type tracker;

   ffsa_req_if req_ch ();
   ffsa_rsp_if rsp_ch ();
   ffsa_csr_if csr_ch ();

   first_fit_segment_allocator_core #(
      .MAX_SEGMENTS(SEG_SLOTS),
      .ADDR_BITS   (16)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99, 0) >= 31);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_result(rsp_ch.status, rsp_ch.addr_res, rsp_ch.size_res);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(kind_type k, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] s);
      while (!no_idle && $urandom_range(99, 0) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= k;
      req_ch.addr  <= a;
      req_ch.size  <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.take_request(k, a, s);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_space(logic [FIELD_W-1:0] space);
      csr_ch.valid       <= 1'b1;
      csr_ch.total_space <= space;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      tracker.rebuild(space);
   endtask

   function automatic int pick_segment(bit want_used);
      int hits[$];
      for (int i = 0; i < tracker.seg_count; i++) begin
         if (tracker.seg_used[i] == want_used) hits.push_back(i);
      end
      if (hits.size() == 0) return -1;
      return hits[$urandom_range(hits.size() - 1, 0)];
   endfunction

   task automatic random_request(int unsigned alloc_pct, int unsigned chunk);
      int unsigned        roll;
      int                 idx;
      kind_type           k;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] s;
      roll = $urandom_range(99, 0);
      a    = FIELD_W'($urandom);
      s    = FIELD_W'($urandom);
      if (roll < alloc_pct) begin
         k    = KIND_ALLOC;
         roll = $urandom_range(19, 0);
         idx  = pick_segment(1'b0);
         if (roll == 1) s = '0;
         else if (roll < 4 && idx >= 0) s = FIELD_W'(tracker.seg_len[idx]);
         else if (roll >= 4) s = FIELD_W'($urandom_range(chunk, 1));
      end else if (roll < alloc_pct + 35) begin
         k    = KIND_FREE;
         roll = $urandom_range(9, 0);
         idx  = pick_segment(1'b1);
         if (roll < 9 && idx >= 0) begin
            a = FIELD_W'(tracker.seg_base[idx]);
            s = FIELD_W'(tracker.seg_len[idx]);
            if (roll == 8) begin
               if ($urandom_range(1, 0) != 0) a = a + 1'b1;
               else s = s - 1'b1;
            end
         end
      end else if (roll < alloc_pct + 45) begin
         k = KIND_REDUCE;
      end else begin
         k = KIND_EXPAND;
         if ($urandom_range(9, 0) != 0) s = FIELD_W'($urandom_range(chunk, 0));
      end
      send_request(k, a, s);
   endtask

   task automatic run_phase(logic [FIELD_W-1:0] space, int unsigned count,
                            int unsigned alloc_pct, int unsigned chunk);
      drain_results();
      write_space(space);
      repeat (count) random_request(alloc_pct, chunk);
   endtask

   initial begin
      logic [FIELD_W-1:0] space;
      tracker = new();
      tracker.rebuild(TOTAL_SPACE_RESET);
      no_idle            = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_ALLOC;
      req_ch.addr        = '0;
      req_ch.size        = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.total_space = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_EXPAND, 16'h0000, 16'd1);
      send_request(KIND_EXPAND, 16'hFFFF, 16'd0);
      send_request(KIND_ALLOC,  16'hFFFF, 16'd0);
      send_request(KIND_FREE,   16'd0,    16'd0);
      send_request(KIND_ALLOC,  16'h0000, 16'd100);
      send_request(KIND_ALLOC,  16'h0000, 16'd65535);
      send_request(KIND_ALLOC,  16'h0000, 16'd200);
      send_request(KIND_FREE,   16'd0,    16'd100);
      send_request(KIND_FREE,   16'd0,    16'd100);
      send_request(KIND_FREE,   16'd100,  16'd201);
      send_request(KIND_FREE,   16'd100,  16'd200);
      send_request(KIND_REDUCE, 16'hFFFF, 16'hFFFF);
      send_request(KIND_EXPAND, 16'h0000, 16'd1);
      send_request(KIND_ALLOC,  16'h0000, 16'd65535);
      send_request(KIND_REDUCE, 16'h0000, 16'h0000);
      send_request(KIND_EXPAND, 16'h0000, 16'd1);
      send_request(KIND_EXPAND, 16'h0000, 16'd0);
      send_request(KIND_REDUCE, 16'h0000, 16'h0000);
      send_request(KIND_EXPAND, 16'h0000, 16'd1);
      send_request(KIND_FREE,   16'd0,    16'd65535);

      run_phase(16'd65535, 400, 40, 2048);
      no_idle = 1'b1;
      repeat (200) random_request(40, 2048);
      no_idle = 1'b0;
      run_phase(16'd0, 300, 35, 16);
      run_phase(16'd300, 300, 55, 6);
      space = FIELD_W'($urandom_range(SPACE_MAX, 1));
      run_phase(space, 300, 45, space / 40 + 1);

      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
